// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define AST_IMP(label, clk, rst_n, ante, cons)
`define AST_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tfr_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam logic [7:0] C_END_MARK  = 8'hFF;  // frame terminator byte
    localparam int         C_POS_W     = 6;      // widest buffer position (depth 64)
    localparam int         C_MAX_OUT   = 32;     // most bytes dumped per frame
    localparam int         C_FIFO_DEPTH = 4;
    localparam int         C_FIFO_AW   = 2;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic               is_end;  // terminator: store it, then dump the frame
        logic [7:0]         data;
        logic [C_POS_W-1:0] pos;
    } t_cmd;

    // Front status, visible for checking.
    typedef struct packed {
        logic               rx_en;
        logic [C_POS_W-1:0] wpos;
    } t_front_stat;

endpackage

// ===== rtl/tfr_front.sv =====
// ----------------------------------------------------------------------------
// tfr_front
// Accepts received bytes, tracks the write position and issues commands.
// ----------------------------------------------------------------------------
module tfr_front #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_line_error,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    output logic                  o_push,
    output tfr_pkg::t_cmd         o_cmd,
    input  logic                  i_full,
    output tfr_pkg::t_front_stat  o_stat
);
    import tfr_pkg::*;

    localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic          r_rx_en;
    logic [PW-1:0] r_wpos;
    logic [PW-1:0] n_wpos;
    logic          w_acc;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;

    always_comb begin
        n_wpos       = r_wpos;
        o_push       = 1'b0;
        o_cmd.is_end = (i_rx_byte == C_END_MARK);
        o_cmd.data   = i_rx_byte;
        o_cmd.pos    = C_POS_W'(r_wpos);
        if (w_acc && r_rx_en) begin
            if (i_line_error) begin
                n_wpos = '0;
            end else begin
                o_push = 1'b1;
                if (o_cmd.is_end) begin
                    n_wpos = '0;
                end else if (r_wpos == PW'(BUFFER_DEPTH - 1)) begin
                    n_wpos = '0;  // wrap without terminator
                end else begin
                    n_wpos = r_wpos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_en <= 1'b1;
            r_wpos  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rx_en <= i_cfg_wdata;
            end
            r_wpos <= n_wpos;
        end
    end

    assign o_stat.rx_en = r_rx_en;
    assign o_stat.wpos  = C_POS_W'(r_wpos);

endmodule

// ===== rtl/tfr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tfr_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tfr_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tfr_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output tfr_pkg::t_cmd  o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import tfr_pkg::*;

    t_cmd                 r_mem [C_FIFO_DEPTH];
    logic [C_FIFO_AW-1:0] r_wr_ptr;
    logic [C_FIFO_AW-1:0] r_rd_ptr;
    logic [C_FIFO_AW:0]   r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full    = (r_count == (C_FIFO_AW + 1)'(C_FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_cmd     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/tfr_back.sv =====
// ----------------------------------------------------------------------------
// tfr_back
// Executes commands: stores bytes in the frame buffer and dumps frames.
// ----------------------------------------------------------------------------
module tfr_back #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  tfr_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_busy,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_frame_byte,
    output logic [4:0]     o_byte_index,
    output logic [5:0]     o_frame_length,
    output logic           o_last
);
    import tfr_pkg::*;

    localparam int  PW     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int  XW     = C_POS_W + 1;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic          r_state;
    logic [PW-1:0] r_rd_idx;
    logic [PW-1:0] r_end;
    logic [5:0]    r_len;
    logic [7:0]    r_rd_data;
    logic          r_s1_vld;
    logic [4:0]    r_s1_idx;
    logic [5:0]    r_s1_len;
    logic          r_s1_last;
    logic          r_out_vld;

    logic          w_out_rdy;
    logic          w_s1_adv;
    logic          w_s1_free;
    logic          w_issue;
    logic [PW-1:0] w_pos;
    logic [XW-1:0] w_len_x;
    logic [XW-1:0] w_first_x;
    logic [XW-1:0] w_idx_x;

    assign w_out_rdy = !r_out_vld || !i_stall;
    assign w_s1_adv  = r_s1_vld && w_out_rdy;
    assign w_s1_free = !r_s1_vld || w_s1_adv;
    assign w_issue   = (r_state == S_DUMP) && w_s1_free;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign o_busy    = (r_state == S_DUMP);

    // Frame of more than 32 bytes: dump only its last 32.
    assign w_pos     = i_cmd.pos[PW-1:0];
    assign w_len_x   = XW'(w_pos) + XW'(1);
    assign w_first_x = (w_len_x > XW'(C_MAX_OUT)) ? (w_len_x - XW'(C_MAX_OUT)) : '0;
    assign w_idx_x   = XW'(r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[w_pos] <= i_cmd.data;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.is_end) begin
                        r_state <= S_DUMP;
                    end
                end
                S_DUMP: begin
                    if (w_issue && (r_rd_idx == r_end)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_issue) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_out_rdy) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_end) begin
            r_rd_idx <= w_first_x[PW-1:0];
            r_end    <= w_pos;
            r_len    <= w_len_x[5:0];
        end else if (w_issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        if (w_issue) begin
            r_s1_idx  <= w_idx_x[4:0];
            r_s1_len  <= r_len;
            r_s1_last <= (r_rd_idx == r_end);
        end
        if (w_s1_adv) begin
            o_frame_byte   <= r_rd_data;
            o_byte_index   <= r_s1_idx;
            o_frame_length <= r_s1_len;
            o_last         <= r_s1_last;
        end
    end

    assign o_valid = r_out_vld;

endmodule

// ===== rtl/terminator_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// terminator_frame_receiver_unit
// Terminator-delimited frame receiver: buffers good serial bytes and emits
// the whole frame, terminator included, when byte 0xFF arrives.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_rx_byte, i_line_error
//  output    out        o_valid / i_stall         o_frame_byte, o_byte_index,
//                                                 o_frame_length, o_last
//  config    in         i_cfg_we                  i_cfg_wdata (receive enable)
//
//  The front handles an ordinary byte, a line error or a disabled-receive
//  item as it accepts it; the back stores a byte when it pops the command.
//  A terminator keeps the back busy while it reads out min(L, 32) bytes of
//  an L-byte frame (one buffer read port, one byte a cycle unless the output
//  stalls); each byte passes the buffer read register, then the output register.
//  A four-entry command queue parts the two sides: o_stall rises only while
//  it is full, so input keeps flowing during a frame dump.
//  Reset is synchronous, active low; it clears the position, the queue and
//  the output valid, and sets receive enable. The buffer is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module terminator_frame_receiver_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_line_error,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic [4:0] o_byte_index,
    output logic [5:0] o_frame_length,
    output logic       o_last
);
    import tfr_pkg::*;

    t_cmd        w_push_cmd;
    t_cmd        w_pop_cmd;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    logic        w_busy;
    t_front_stat w_stat;

    // Front: accept and classify items, own the write position.
    tfr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_line_error (i_line_error),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd),
        .i_full       (w_full),
        .o_stat       (w_stat)
    );

    // Queue: hold commands while the back is dumping a frame.
    tfr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back: write the buffer, read frames out through a registered pipeline.
    tfr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_cmd          (w_pop_cmd),
        .o_pop          (w_pop),
        .o_busy         (w_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_byte   (o_frame_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

    // The last byte of a frame sits at position length - 1 (within 5 bits).
    `AST_IMP(a_last_index, i_clk, i_rst_n, o_valid && o_last, o_byte_index == 5'(o_frame_length - 6'd1))
    // An accepted line error with receive enabled returns the position to 0.
    `AST_NXT(a_err_clears, i_clk, i_rst_n, i_valid && !o_stall && w_stat.rx_en && i_line_error, w_stat.wpos == '0)
    // A terminator taken in always lands in the queue.
    `AST_NXT(a_end_queued, i_clk, i_rst_n, i_valid && !o_stall && w_stat.rx_en && !i_line_error && (i_rx_byte == C_END_MARK), !w_empty)
    // The back never takes a command while dumping a frame.
    `AST_IMP(a_no_pop_busy, i_clk, i_rst_n, w_busy, !w_pop)

endmodule

// ===== dv/tb_terminator_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_terminator_frame_receiver_unit
// Self-checking bench for the terminator-delimited frame receiver. A clocked
// driver feeds received bytes from a pending queue, and a clocked monitor
// checks every dumped frame byte against a bench-side frame predictor.
// ----------------------------------------------------------------------------
module tb_terminator_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tfr_pkg::*;

    localparam int BUFFER_DEPTH     = 32;
    localparam int LONG_HOLD_CYCLES = 300;    // receiver hold-off in the pressure phase
    localparam int SETTLE_CYCLES    = 16;     // back-end catch-up before a config write
    localparam int DRAIN_LIMIT      = 20000;  // cycles to wait for a drain before giving up

    // One received byte as the serial side hands it over.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } rx_item_t;

    // One dumped frame byte as the block should present it.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [4:0] byte_index;
        logic [5:0] frame_length;
        logic       is_last;
    } frame_byte_t;

    // DUT ports; every input starts at a known value
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte    = 8'h00;
    logic       i_line_error = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic       i_cfg_wdata  = 1'b1;
    logic       o_valid;
    logic       i_stall      = 1'b0;
    logic [7:0] o_frame_byte;
    logic [4:0] o_byte_index;
    logic [5:0] o_frame_length;
    logic       o_last;

    // Stimulus and expectation stores
    rx_item_t    rx_pending[$];        // bytes waiting to be offered, front is on the bus
    frame_byte_t frame_bytes_due[$];   // predicted frame bytes, oldest first

    // Predictor state: receive enable, write position, frame buffer
    logic       rx_on = 1'b1;
    int         wr_pos = 0;
    logic [7:0] byte_mem [BUFFER_DEPTH];

    // Idle control, written by the sequencer at falling edges only
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;

    // Bookkeeping
    int          mismatch_count   = 0;
    int          items_queued     = 0;
    int          items_accepted   = 0;
    int          bytes_checked    = 0;
    int          frames_checked   = 0;
    int          cfg_writes       = 0;
    int          input_held_cycles = 0;
    int          send_gap_left    = 0;
    int          recv_gap_left    = 0;
    int          hold_left        = 0;
    bit          hold_served      = 1'b0;
    bit          item_taken;
    rx_item_t    taken_item;
    frame_byte_t oldest_due;

    terminator_frame_receiver_unit #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_line_error   (i_line_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_byte   (o_frame_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Frame predictor: apply one accepted byte to the bench copy of the
    // receiver and queue every frame byte it releases.
    // ------------------------------------------------------------------
    task automatic absorb_rx_byte(rx_item_t it);
        int          pos;
        int          len;
        int          first;
        frame_byte_t fb;
        // disabled receive swallows everything, line errors included
        if (rx_on && it.line_error) begin
            wr_pos = 0;
        end else if (rx_on) begin
            pos = wr_pos;
            byte_mem[pos] = it.rx_byte;
            if (it.rx_byte != C_END_MARK) begin
                // advance, wrap past the buffer end
                wr_pos = (pos + 1) % BUFFER_DEPTH;
            end else begin
                // terminator: dump position 0 through the terminator
                len   = pos + 1;
                first = (len > C_MAX_OUT) ? len - C_MAX_OUT : 0;
                for (int k = first; k < len; k++) begin
                    fb.frame_byte   = byte_mem[k];
                    fb.byte_index   = 5'(k);
                    fb.frame_length = 6'(len);
                    fb.is_last      = (k == pos);
                    frame_bytes_due.push_back(fb);
                end
                wr_pos = 0;
            end
        end
    endtask

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the front of the pending queue. Hold the payload while
    // stalled, pop and predict on acceptance, and insert random gaps only
    // between items so valid never reacts to stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            send_gap_left = 0;
        end else begin
            item_taken = i_valid && !o_stall;
            if (item_taken) begin
                taken_item = rx_pending.pop_front();
                absorb_rx_byte(taken_item);
                items_accepted++;
            end
            if (!i_valid || item_taken) begin
                if (send_gap_left > 0) begin
                    send_gap_left--;
                    i_valid <= 1'b0;
                end else if (rx_pending.size() != 0 && send_idle_pct != 0 &&
                             $urandom_range(0, 99) < send_idle_pct) begin
                    // start an idle burst, this one included
                    send_gap_left = $urandom_range(1, 19) - 1;
                    i_valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    i_valid      <= 1'b1;
                    i_rx_byte    <= rx_pending[0].rx_byte;
                    i_line_error <= rx_pending[0].line_error;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: one long hold-off on request (counted here), else
    // random stall bursts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = LONG_HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (recv_gap_left > 0) begin
            recv_gap_left--;
            i_stall <= 1'b1;
        end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap_left = $urandom_range(1, 19) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted frame byte with the oldest prediction,
    // field by field. Also count cycles the block pushed back on input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall)
                input_held_cycles++;
            if (o_valid && !i_stall) begin
                if (frame_bytes_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected frame byte %h index %0d",
                                            o_frame_byte, o_byte_index));
                end else begin
                    oldest_due = frame_bytes_due.pop_front();
                    bytes_checked++;
                    if (oldest_due.is_last)
                        frames_checked++;
                    if (o_frame_byte !== oldest_due.frame_byte)
                        flag_mismatch($sformatf("frame_byte %h, want %h",
                                                o_frame_byte, oldest_due.frame_byte));
                    if (o_byte_index !== oldest_due.byte_index)
                        flag_mismatch($sformatf("byte_index %0d, want %0d",
                                                o_byte_index, oldest_due.byte_index));
                    if (o_frame_length !== oldest_due.frame_length)
                        flag_mismatch($sformatf("frame_length %0d, want %0d",
                                                o_frame_length, oldest_due.frame_length));
                    if (o_last !== oldest_due.is_last)
                        flag_mismatch($sformatf("last %b, want %b",
                                                o_last, oldest_due.is_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers. All queue and knob updates happen at falling
    // edges so the clocked processes see them in a fixed order.
    // ------------------------------------------------------------------
    task automatic queue_rx(logic [7:0] b, logic err);
        rx_item_t it;
        it.rx_byte    = b;
        it.line_error = err;
        rx_pending.push_back(it);
        items_queued++;
    endtask

    // Body of random non-terminator bytes, an optional line error at a random
    // point (which restarts the frame), then the terminator.
    task automatic queue_frame(int body_len, bit with_error);
        int err_at;
        err_at = with_error ? $urandom_range(0, body_len) : -1;
        for (int k = 0; k < body_len; k++) begin
            if (k == err_at)
                queue_rx(8'($urandom_range(0, 255)), 1'b1);
            queue_rx(8'($urandom_range(0, 254)), 1'b0);
        end
        if (err_at == body_len)
            queue_rx(8'($urandom_range(0, 255)), 1'b1);
        queue_rx(C_END_MARK, 1'b0);
    endtask

    // Mostly well-formed frames with random content, some noise.
    task automatic queue_random_traffic(int n_items);
        int stop_at;
        int pick;
        stop_at = items_queued + n_items;
        while (items_queued < stop_at) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4))
                    queue_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
            end else if (pick == 1) begin
                queue_frame($urandom_range(20, 31), 1'b0);
            end else begin
                queue_frame($urandom_range(0, 8), $urandom_range(0, 5) == 0);
            end
        end
    endtask

    // Wait until the bench has nothing in flight, flush leftovers as
    // failures, then let the back end settle.
    task automatic wait_drained(int settle);
        int spins;
        spins = 0;
        while ((rx_pending.size() != 0 || i_valid || frame_bytes_due.size() != 0) &&
               spins < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spins++;
        end
        if (spins >= DRAIN_LIMIT)
            flag_mismatch($sformatf("drain timed out, %0d items still pending",
                                    rx_pending.size()));
        if (frame_bytes_due.size() != 0) begin
            flag_mismatch($sformatf("%0d frame bytes never arrived", frame_bytes_due.size()));
            frame_bytes_due.delete();
        end
        repeat (settle) @(negedge i_clk);
    endtask

    // Write receive enable while idle; the block takes it at the edge on which the task drops the write enable.
    task automatic write_rx_enable(logic on);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rx_on = on;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: lone terminator, byte extremes, line errors mid-frame,
        // a line error carrying the terminator value, error on the first byte.
        send_idle_pct = 25;
        recv_idle_pct = 25;
        queue_rx(C_END_MARK, 1'b0);
        queue_rx(8'h00, 1'b0);
        queue_rx(8'h7F, 1'b0);
        queue_rx(8'h80, 1'b0);
        queue_rx(8'hFE, 1'b0);
        queue_rx(8'h55, 1'b0);
        queue_rx(8'hAA, 1'b0);
        queue_rx(C_END_MARK, 1'b0);
        queue_rx(8'h11, 1'b0);
        queue_rx(8'h22, 1'b0);
        queue_rx(8'h33, 1'b1);
        queue_rx(8'h44, 1'b0);
        queue_rx(C_END_MARK, 1'b0);
        queue_rx(C_END_MARK, 1'b1);
        queue_rx(C_END_MARK, 1'b0);
        queue_rx(8'h00, 1'b1);
        queue_rx(8'h01, 1'b0);
        queue_rx(C_END_MARK, 1'b0);
        // leave a partial frame behind before disabling
        queue_rx(8'h01, 1'b0);
        queue_rx(8'h02, 1'b0);
        wait_drained(SETTLE_CYCLES);

        // Receive disabled: terminator and line error alike must be dropped
        // and the partial frame must survive.
        write_rx_enable(1'b0);
        queue_rx(8'h0A, 1'b0);
        queue_rx(C_END_MARK, 1'b1);
        queue_rx(C_END_MARK, 1'b0);
        queue_rx(8'h0B, 1'b1);
        wait_drained(SETTLE_CYCLES);
        write_rx_enable(1'b1);
        queue_rx(C_END_MARK, 1'b0);
        wait_drained(SETTLE_CYCLES);

        // Random traffic under three idle mixes; open with a full-length
        // frame and one that wraps the buffer.
        queue_frame(31, 1'b0);
        queue_frame(32, 1'b0);
        send_idle_pct = 30;
        recv_idle_pct = 0;
        queue_random_traffic(5);
        wait_drained(0);
        send_idle_pct = 0;
        recv_idle_pct = 30;
        queue_random_traffic(5);
        wait_drained(0);
        send_idle_pct = 15;
        recv_idle_pct = 15;
        queue_random_traffic(5);
        wait_drained(SETTLE_CYCLES);

        // Second disabled stretch with noise, then back on.
        write_rx_enable(1'b0);
        repeat (4)
            queue_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_drained(SETTLE_CYCLES);
        write_rx_enable(1'b1);

        // Pressure: hold the receiver off while the sender keeps offering
        // short frames, so the command queue fills and input stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        queue_frame(2, 1'b0);
        repeat (4)
            queue_frame($urandom_range(1, 3), 1'b0);
        wait_drained(0);

        // Tail: no idling on either side.
        queue_random_traffic(6);
        wait_drained(40);

        $display("summary: %0d items accepted (%0d queued),", items_accepted, items_queued);
        $display("summary: %0d frame bytes in %0d frames checked", bytes_checked,
                 frames_checked);
        $display("summary: %0d receive-enable writes, input held off %0d cycles, %0d mismatches",
                 cfg_writes, input_held_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
